// File: rtl/opt_pkg.sv
// package for the outstanding probe tracker
// holds operation and status codes, register indexes, reset values and the table entry type
// no dependencies
package opt_pkg;

   // operation codes of the input item
   localparam logic [1:0] OP_SEND   = 2'd0;
   localparam logic [1:0] OP_REPLY  = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;
   localparam logic [1:0] OP_STATS  = 2'd3;

   // reply status codes of the result item
   localparam logic [1:0] RS_NONE       = 2'd0;
   localparam logic [1:0] RS_MATCHED    = 2'd1;
   localparam logic [1:0] RS_IGNORED    = 2'd2;
   localparam logic [1:0] RS_UNEXPECTED = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_OUTSTANDING = 2'd0;
   localparam logic [1:0] CSR_PAYLOAD_BYTES   = 2'd1;
   localparam logic [1:0] CSR_DEADLINE_MS     = 2'd2;

   localparam logic [6:0]  MAX_OUT_RESET  = 7'd50;
   localparam logic [15:0] PAYLOAD_RESET  = 16'd1024;
   localparam logic [15:0] DEADLINE_RESET = 16'd5000;
   localparam logic [15:0] SEQ_START      = 16'd4040;

   // reply checks
   localparam logic [15:0] MIN_REPLY_LEN      = 16'd56;
   localparam logic [7:0]  ICMP_TIME_EXCEEDED = 8'd11;
   localparam logic [7:0]  ICMP_TTL_IN_TRANSIT = 8'd0;
   localparam logic [7:0]  PROTO_UDP          = 8'd17;

   localparam logic [31:0] CNT32_MAX = 32'hFFFF_FFFF;
   localparam logic [47:0] CNT48_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] sequence_num;
      logic [47:0] deadline;
   } entry_type;

endpackage

// File: rtl/outstanding_probe_tracker_core.sv
// outstanding probe tracker, top level
// table of outstanding probes kept in one memory, swept entry by entry; uses opt_pkg

// A send, a reply that passes its header checks, and an expire tick each sweep the
// whole probe table through one read port and one shared compare unit, one entry a
// cycle; a stats tick, a refused send and a reply that is ignored or meets an empty table
// skip the sweep and go straight to the final state. The block is ready for the next item
// in the cycle after the result is loaded, and a result held by rsp_stall keeps the next
// one waiting in its final state. After reset the block runs a clearing pass over every
// table entry before it takes the first item; configuration writes are taken at any
// time.
// A new item is taken while the previous result still waits on the rsp side.
module outstanding_probe_tracker_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [47:0] req_now_ms,
   input  logic [15:0] req_recv_length,
   input  logic [7:0]  req_icmp_type,
   input  logic [7:0]  req_icmp_code,
   input  logic [7:0]  req_inner_protocol,
   input  logic [15:0] req_reply_port,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_grant,
   output logic [15:0] rsp_send_sequence,
   output logic [1:0]  rsp_reply_status,
   output logic        rsp_stats_valid,
   output logic [31:0] rsp_matched_packets,
   output logic [47:0] rsp_matched_bytes,
   output logic [6:0]  rsp_occupancy,
   output logic [31:0] rsp_expired_count
);
   import opt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = CW + 7;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   state_type state_ff, state_in;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   logic [CW-1:0] idx_ff, idx_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;

   logic [1:0]  op_ff, op_in;
   logic [47:0] now_ff, now_in;
   logic [15:0] key_ff, key_in;
   logic [47:0] dl_ff, dl_in;
   logic        grant_ff, grant_in;
   logic        scan_rpl_ff, scan_rpl_in;
   logic [1:0]  pre_status_ff, pre_status_in;

   logic          found_ff, found_in;
   logic [AW-1:0] hit_addr_ff, hit_addr_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_addr_ff, free_addr_in;

   logic [15:0]   next_seq_ff, next_seq_in;
   logic [31:0]   pkt_ff, pkt_in;
   logic [47:0]   byte_ff, byte_in;
   logic [31:0]   exp_ff, exp_in;
   logic [CW-1:0] count_ff, count_in;

   logic [6:0]  max_out_ff, max_out_in;
   logic [15:0] payload_ff, payload_in;
   logic [15:0] deadline_ff, deadline_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_grant_ff, rsp_grant_in;
   logic [15:0] rsp_seq_ff, rsp_seq_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_sv_ff, rsp_sv_in;
   logic [31:0] rsp_pkt_ff, rsp_pkt_in;
   logic [47:0] rsp_byte_ff, rsp_byte_in;
   logic [6:0]  rsp_occ_ff, rsp_occ_in;
   logic [31:0] rsp_exp_ff, rsp_exp_in;

   logic          accept;
   logic          load;
   logic          send_ok;
   logic          reply_ok;
   logic          need_scan;
   logic          scan_end;
   logic [15:0]   seq_plus;
   logic [48:0]   dl_sum;
   logic [48:0]   byte_sum;
   logic          ent_hit;
   logic          ent_free;
   logic          ent_late;
   logic [CW+6:0] occ_wide;

   assign accept   = req_valid && !req_stall;
   assign load     = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign send_ok  = (EW'(count_ff) < EW'(max_out_ff)) && (count_ff != DEPTH_C);
   assign reply_ok = (req_recv_length >= MIN_REPLY_LEN) && (req_icmp_type == ICMP_TIME_EXCEEDED)
                     && (req_icmp_code == ICMP_TTL_IN_TRANSIT) && (req_inner_protocol == PROTO_UDP);
   assign seq_plus = next_seq_ff + 16'd1;
   assign dl_sum   = {1'b0, req_now_ms} + {33'd0, deadline_ff};
   assign byte_sum = {1'b0, byte_ff} + {33'd0, payload_ff};
   assign scan_end = (idx_ff == DEPTH_C) && !chk_vld_ff;

   always_comb begin
      case (req_operation)
         OP_SEND:   need_scan = send_ok;
         OP_REPLY:  need_scan = (count_ff != '0) && reply_ok;
         OP_EXPIRE: need_scan = 1'b1;
         default:   need_scan = 1'b0;
      endcase
   end

   // shared compare unit on the entry read out in the previous cycle
   assign ent_hit  = rd_data_ff.valid && (rd_data_ff.sequence_num == key_ff);
   assign ent_free = !rd_data_ff.valid;
   assign ent_late = rd_data_ff.valid && (rd_data_ff.deadline < now_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_C) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = need_scan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (scan_end) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      wr_en         = 1'b0;
      wr_addr       = chk_addr_ff;
      wr_data       = rd_data_ff;
      rd_addr       = idx_ff[AW-1:0];
      idx_in        = idx_ff;
      chk_vld_in    = 1'b0;
      chk_addr_in   = idx_ff[AW-1:0];
      op_in         = op_ff;
      now_in        = now_ff;
      key_in        = key_ff;
      dl_in         = dl_ff;
      grant_in      = grant_ff;
      scan_rpl_in   = scan_rpl_ff;
      pre_status_in = pre_status_ff;
      found_in      = found_ff;
      hit_addr_in   = hit_addr_ff;
      free_found_in = free_found_ff;
      free_addr_in  = free_addr_ff;
      next_seq_in   = next_seq_ff;
      pkt_in        = pkt_ff;
      byte_in       = byte_ff;
      exp_in        = exp_ff;
      count_in      = count_ff;
      max_out_in    = max_out_ff;
      payload_in    = payload_ff;
      deadline_in   = deadline_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_grant_in  = rsp_grant_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sv_in     = rsp_sv_ff;
      rsp_pkt_in    = rsp_pkt_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_exp_in    = rsp_exp_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_OUTSTANDING: max_out_in  = csr_wr_data[6:0];
            CSR_PAYLOAD_BYTES:   payload_in  = csr_wr_data;
            CSR_DEADLINE_MS:     deadline_in = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
            idx_in  = (idx_ff == LAST_C) ? '0 : idx_ff + ONE_C;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in         = req_operation;
               now_in        = req_now_ms;
               dl_in         = dl_sum[48] ? CNT48_MAX : dl_sum[47:0];
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               grant_in      = (req_operation == OP_SEND) && send_ok;
               scan_rpl_in   = (req_operation == OP_REPLY) && need_scan;
               pre_status_in = RS_NONE;
               key_in        = req_reply_port;
               if (req_operation == OP_SEND && send_ok) begin
                  key_in      = seq_plus;
                  next_seq_in = seq_plus;
               end
               if (req_operation == OP_REPLY && count_ff != '0 && !reply_ok) begin
                  pre_status_in = RS_IGNORED;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff != DEPTH_C) begin
               chk_vld_in = 1'b1;
               idx_in     = idx_ff + ONE_C;
            end
            if (chk_vld_ff) begin
               if (op_ff == OP_EXPIRE) begin
                  if (ent_late) begin
                     wr_en          = 1'b1;
                     wr_data.valid  = 1'b0;
                     count_in       = count_ff - ONE_C;
                     exp_in         = (exp_ff == CNT32_MAX) ? exp_ff : exp_ff + 32'd1;
                  end
               end else begin
                  // first matching entry and first free entry
                  if (ent_hit && !found_ff) begin
                     found_in    = 1'b1;
                     hit_addr_in = chk_addr_ff;
                  end
                  if (ent_free && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_addr_in  = chk_addr_ff;
                  end
               end
            end
         end
         ST_DONE: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = grant_ff;
               rsp_seq_in    = grant_ff ? key_ff : 16'd0;
               rsp_status_in = pre_status_ff;
               rsp_sv_in     = 1'b0;
               rsp_pkt_in    = '0;
               rsp_byte_in   = '0;
               rsp_exp_in    = '0;
               if (grant_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = found_ff ? hit_addr_ff : free_addr_ff;
                  wr_data = '{valid: 1'b1, sequence_num: key_ff, deadline: dl_ff};
                  if (!found_ff) count_in = count_ff + ONE_C;
               end
               if (scan_rpl_ff) begin
                  if (found_ff) begin
                     rsp_status_in = RS_MATCHED;
                     wr_en         = 1'b1;
                     wr_addr       = hit_addr_ff;
                     wr_data       = '0;
                     count_in      = count_ff - ONE_C;
                     pkt_in        = (pkt_ff == CNT32_MAX) ? pkt_ff : pkt_ff + 32'd1;
                     byte_in       = byte_sum[48] ? CNT48_MAX : byte_sum[47:0];
                  end else begin
                     rsp_status_in = RS_UNEXPECTED;
                  end
               end
               if (op_ff == OP_STATS) begin
                  rsp_sv_in   = 1'b1;
                  rsp_pkt_in  = pkt_ff;
                  rsp_byte_in = byte_ff;
                  rsp_exp_in  = exp_ff;
                  pkt_in      = '0;
                  byte_in     = '0;
                  exp_in      = '0;
               end
               occ_wide   = {7'd0, count_in};
               rsp_occ_in = occ_wide[6:0];
            end
         end
         default: ;
      endcase
      occ_wide = {7'd0, count_in};
   end

   // probe table, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         next_seq_ff  <= SEQ_START;
         pkt_ff       <= '0;
         byte_ff      <= '0;
         exp_ff       <= '0;
         count_ff     <= '0;
         max_out_ff   <= MAX_OUT_RESET;
         payload_ff   <= PAYLOAD_RESET;
         deadline_ff  <= DEADLINE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         chk_vld_ff   <= chk_vld_in;
         next_seq_ff  <= next_seq_in;
         pkt_ff       <= pkt_in;
         byte_ff      <= byte_in;
         exp_ff       <= exp_in;
         count_ff     <= count_in;
         max_out_ff   <= max_out_in;
         payload_ff   <= payload_in;
         deadline_ff  <= deadline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff   <= chk_addr_in;
      op_ff         <= op_in;
      now_ff        <= now_in;
      key_ff        <= key_in;
      dl_ff         <= dl_in;
      grant_ff      <= grant_in;
      scan_rpl_ff   <= scan_rpl_in;
      pre_status_ff <= pre_status_in;
      found_ff      <= found_in;
      hit_addr_ff   <= hit_addr_in;
      free_found_ff <= free_found_in;
      free_addr_ff  <= free_addr_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sv_ff     <= rsp_sv_in;
      rsp_pkt_ff    <= rsp_pkt_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_exp_ff    <= rsp_exp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_send_grant      = rsp_grant_ff;
   assign rsp_send_sequence   = rsp_seq_ff;
   assign rsp_reply_status    = rsp_status_ff;
   assign rsp_stats_valid     = rsp_sv_ff;
   assign rsp_matched_packets = rsp_pkt_ff;
   assign rsp_matched_bytes   = rsp_byte_ff;
   assign rsp_occupancy       = rsp_occ_ff;
   assign rsp_expired_count   = rsp_exp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("outstanding count above table depth");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= DEPTH_C)
      else $error("sweep index past table end");

   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("item taken during clearing pass");

   a_match_drops_count: assert property (@(posedge clock) disable iff (reset)
      (load && scan_rpl_ff && found_ff) |=> (count_ff + ONE_C == $past(count_ff)))
      else $error("matched reply did not release its entry");

   a_grant_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_grant_ff) |-> (rsp_status_ff == RS_NONE && !rsp_sv_ff))
      else $error("granted send carries reply or stats fields");
`endif

endmodule

// File: dv/probe_tracker_checker.sv
// checker for the outstanding probe tracker: watches the csr, req and rsp channels,
// keeps its own model of the probe table and compares every result item in order
// depends on opt_pkg for operation, status and register codes
module probe_tracker_checker #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [47:0] req_now_ms,
   input  logic [15:0] req_recv_length,
   input  logic [7:0]  req_icmp_type,
   input  logic [7:0]  req_icmp_code,
   input  logic [7:0]  req_inner_protocol,
   input  logic [15:0] req_reply_port,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_send_grant,
   input  logic [15:0] rsp_send_sequence,
   input  logic [1:0]  rsp_reply_status,
   input  logic        rsp_stats_valid,
   input  logic [31:0] rsp_matched_packets,
   input  logic [47:0] rsp_matched_bytes,
   input  logic [6:0]  rsp_occupancy,
   input  logic [31:0] rsp_expired_count,

   output int          fail_count,
   output int          pending_results
);
   import opt_pkg::*;

   localparam logic [15:0] FIRST_SEQ           = 16'd4040;
   localparam logic [6:0]  MAX_OUT_DEFAULT     = 7'd50;
   localparam logic [15:0] PAYLOAD_DEFAULT     = 16'd1024;
   localparam logic [15:0] DEADLINE_DEFAULT    = 16'd5000;
   localparam logic [15:0] REPLY_MIN_LEN       = 16'd56;
   localparam logic [7:0]  TYPE_TTL_EXCEEDED   = 8'd11;
   localparam logic [7:0]  CODE_TTL_IN_TRANSIT = 8'd0;
   localparam logic [7:0]  INNER_UDP           = 8'd17;

   typedef struct packed {
      logic        grant;
      logic [15:0] seq;
      logic [1:0]  status;
      logic        stats;
      logic [31:0] packets;
      logic [47:0] bytes;
      logic [6:0]  occ;
      logic [31:0] expired;
   } probe_result_type;

   logic [6:0]  cfg_max_out;
   logic [15:0] cfg_payload;
   logic [15:0] cfg_deadline;

   bit          slot_live [DEPTH];
   logic [15:0] slot_seq [DEPTH];
   logic [47:0] slot_deadline [DEPTH];
   logic [15:0] last_seq;
   logic [31:0] packet_tally;
   logic [47:0] byte_tally;
   logic [31:0] expiry_tally;
   int          live_count;

   probe_result_type expected_results [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // applies one item to the model table and returns the result it should produce
   function automatic probe_result_type predict_probe(
      input logic [1:0]  op,
      input logic [47:0] now,
      input logic [15:0] len,
      input logic [7:0]  typ,
      input logic [7:0]  code,
      input logic [7:0]  proto,
      input logic [15:0] port
   );
      probe_result_type r;
      int            hit;
      logic [48:0]   sum;
      r = '0;
      case (op)
         OP_SEND: begin
            if (live_count < cfg_max_out && live_count < DEPTH) begin
               last_seq = last_seq + 16'd1;
               hit = -1;
               for (int i = 0; i < DEPTH; i++)
                  if (hit < 0 && slot_live[i] && slot_seq[i] == last_seq) hit = i;
               if (hit < 0) begin
                  for (int i = 0; i < DEPTH; i++)
                     if (hit < 0 && !slot_live[i]) hit = i;
                  if (hit >= 0) live_count++;
               end
               if (hit >= 0) begin
                  sum = {1'b0, now} + cfg_deadline;
                  slot_live[hit] = 1'b1;
                  slot_seq[hit] = last_seq;
                  slot_deadline[hit] = sum[48] ? '1 : sum[47:0];
               end
               r.grant = 1'b1;
               r.seq = last_seq;
            end
         end
         OP_REPLY: begin
            // an empty table looks at nothing, not even the header checks
            if (live_count > 0) begin
               if (len < REPLY_MIN_LEN || typ != TYPE_TTL_EXCEEDED ||
                   code != CODE_TTL_IN_TRANSIT || proto != INNER_UDP) begin
                  r.status = RS_IGNORED;
               end else begin
                  hit = -1;
                  for (int i = 0; i < DEPTH; i++)
                     if (hit < 0 && slot_live[i] && slot_seq[i] == port) hit = i;
                  if (hit < 0) begin
                     r.status = RS_UNEXPECTED;
                  end else begin
                     slot_live[hit] = 1'b0;
                     live_count--;
                     if (packet_tally != '1) packet_tally++;
                     sum = {1'b0, byte_tally} + cfg_payload;
                     byte_tally = sum[48] ? '1 : sum[47:0];
                     r.status = RS_MATCHED;
                  end
               end
            end
         end
         OP_EXPIRE: begin
            // strictly past only: a deadline equal to now survives
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_live[i] && slot_deadline[i] < now) begin
                  slot_live[i] = 1'b0;
                  live_count--;
                  if (expiry_tally != '1) expiry_tally++;
               end
            end
         end
         default: begin
            r.stats = 1'b1;
            r.packets = packet_tally;
            r.bytes = byte_tally;
            r.expired = expiry_tally;
            packet_tally = '0;
            byte_tally = '0;
            expiry_tally = '0;
         end
      endcase
      r.occ = live_count[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      probe_result_type want;
      if (reset) begin
         cfg_max_out = MAX_OUT_DEFAULT;
         cfg_payload = PAYLOAD_DEFAULT;
         cfg_deadline = DEADLINE_DEFAULT;
         for (int i = 0; i < DEPTH; i++) slot_live[i] = 1'b0;
         last_seq = FIRST_SEQ;
         packet_tally = '0;
         byte_tally = '0;
         expiry_tally = '0;
         live_count = 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAX_OUTSTANDING: cfg_max_out = csr_wr_data[6:0];
               CSR_PAYLOAD_BYTES:   cfg_payload = csr_wr_data;
               CSR_DEADLINE_MS:     cfg_deadline = csr_wr_data;
               default: ;
            endcase
         end
         // a result always belongs to an item taken at an earlier edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result item with nothing pending", 64'(rsp_occupancy),
                               64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_send_grant !== want.grant)
                  report_mismatch("send_grant", 64'(rsp_send_grant), 64'(want.grant));
               if (rsp_send_sequence !== want.seq)
                  report_mismatch("send_sequence", 64'(rsp_send_sequence), 64'(want.seq));
               if (rsp_reply_status !== want.status)
                  report_mismatch("reply_status", 64'(rsp_reply_status), 64'(want.status));
               if (rsp_stats_valid !== want.stats)
                  report_mismatch("stats_valid", 64'(rsp_stats_valid), 64'(want.stats));
               if (rsp_matched_packets !== want.packets)
                  report_mismatch("matched_packets", 64'(rsp_matched_packets),
                                  64'(want.packets));
               if (rsp_matched_bytes !== want.bytes)
                  report_mismatch("matched_bytes", 64'(rsp_matched_bytes), 64'(want.bytes));
               if (rsp_occupancy !== want.occ)
                  report_mismatch("occupancy", 64'(rsp_occupancy), 64'(want.occ));
               if (rsp_expired_count !== want.expired)
                  report_mismatch("expired_count", 64'(rsp_expired_count),
                                  64'(want.expired));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_probe(req_operation, req_now_ms,
               req_recv_length, req_icmp_type, req_icmp_code, req_inner_protocol,
               req_reply_port));
      end
      pending_results <= expected_results.size();
   end

endmodule

// File: dv/testbench.sv
// top of the probe tracker bench: clock, reset, register settings and item stimulus
// depends on opt_pkg, outstanding_probe_tracker_core and probe_tracker_checker
module testbench;
   import opt_pkg::*;

   localparam int          TABLE_DEPTH   = 64;
   localparam int          SETTLE_CYCLES = TABLE_DEPTH + 8;
   localparam int          RANDOM_ITEMS  = 600;
   localparam logic [1:0]  CSR_SPARE     = 2'd3;
   localparam logic [47:0] NOW_MAX       = 48'hFFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic [1:0]  req_operation = '0;
   logic [47:0] req_now_ms = '0;
   logic [15:0] req_recv_length = '0;
   logic [7:0]  req_icmp_type = '0;
   logic [7:0]  req_icmp_code = '0;
   logic [7:0]  req_inner_protocol = '0;
   logic [15:0] req_reply_port = '0;
   logic        rsp_stall = 1'b0;

   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_send_grant;
   logic [15:0] rsp_send_sequence;
   logic [1:0]  rsp_reply_status;
   logic        rsp_stats_valid;
   logic [31:0] rsp_matched_packets;
   logic [47:0] rsp_matched_bytes;
   logic [6:0]  rsp_occupancy;
   logic [31:0] rsp_expired_count;

   int          fail_count;
   int          pending_results;

   int          items_sent = 0;
   int          settings_used = 0;
   int          grants_seen = 0;
   int          matches_seen = 0;
   logic [15:0] granted_seqs [$];
   logic [47:0] clock_ms = 48'd100000;
   bit          req_no_idle = 1'b0;
   int          pressure_req = 0;

   // granted sequences are latched at the edge and queued at the falling edge,
   // so the stimulus never races the monitor
   logic        grant_taken = 1'b0;
   logic [15:0] grant_seq_taken = '0;
   logic        match_taken = 1'b0;

   outstanding_probe_tracker_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (.*);

   probe_tracker_checker #(.DEPTH(TABLE_DEPTH)) u_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      grant_taken <= !reset && rsp_valid && !rsp_stall && rsp_send_grant;
      grant_seq_taken <= rsp_send_sequence;
      match_taken <= !reset && rsp_valid && !rsp_stall && rsp_reply_status == RS_MATCHED;
   end

   always @(negedge clock) begin
      if (grant_taken) begin
         granted_seqs.push_back(grant_seq_taken);
         grants_seen++;
         if (granted_seqs.size() > 256) void'(granted_seqs.pop_front());
      end
      if (match_taken) matches_seen++;
   end

   // receiver: random stalls, one quiet stretch, and a long hold-off on request
   initial begin
      int hold_left = 0;
      int seen = 0;
      int cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (pressure_req != seen) begin
            seen = pressure_req;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (cyc > 8000 && cyc < 14000) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 11);
         end
      end
   end

   function automatic logic [47:0] random_ms();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   task automatic offer_item(input logic [1:0] op, input logic [47:0] now,
                             input logic [15:0] len, input logic [7:0] typ,
                             input logic [7:0] code, input logic [7:0] proto,
                             input logic [15:0] port);
      while (!req_no_idle && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_now_ms <= now;
      req_recv_length <= len;
      req_icmp_type <= typ;
      req_icmp_code <= code;
      req_inner_protocol <= proto;
      req_reply_port <= port;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      // some items produce nothing extra, but let any sweep still running finish
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] max_word, input logic [15:0] payload,
                                 input logic [15:0] deadline);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_OUTSTANDING;
      csr_wr_data <= max_word;
      @(posedge clock);
      csr_index <= CSR_PAYLOAD_BYTES;
      csr_wr_data <= payload;
      @(posedge clock);
      csr_index <= CSR_DEADLINE_MS;
      csr_wr_data <= deadline;
      @(posedge clock);
      // unused index must leave every register alone
      csr_index <= CSR_SPARE;
      csr_wr_data <= 16'($urandom_range(0, 65535));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic random_item();
      int          pick;
      int          k;
      logic [15:0] port;
      logic [15:0] len;
      logic [7:0]  typ;
      logic [7:0]  code;
      logic [7:0]  proto;
      logic [7:0]  flip;
      pick = $urandom_range(0, 99);
      port = 16'($urandom_range(0, 65535));
      flip = 8'($urandom_range(1, 255));
      len = 16'($urandom_range(MIN_REPLY_LEN, 65535));
      typ = ICMP_TIME_EXCEEDED;
      code = ICMP_TTL_IN_TRANSIT;
      proto = PROTO_UDP;
      clock_ms = clock_ms + $urandom_range(0, 2500);
      if (pick < 36) begin
         offer_item(OP_SEND, ($urandom_range(0, 99) < 4) ? random_ms() : clock_ms,
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), port);
      end else if (pick < 66) begin
         if (granted_seqs.size() > 0 && $urandom_range(0, 99) < 85) begin
            k = $urandom_range(0, granted_seqs.size() - 1);
            port = granted_seqs[k];
            granted_seqs.delete(k);
         end
         offer_item(OP_REPLY, clock_ms, len, typ, code, proto, port);
      end else if (pick < 76) begin
         // reply with one header check broken
         if (granted_seqs.size() > 0) port = granted_seqs[$urandom_range(0, granted_seqs.size() - 1)];
         case ($urandom_range(0, 3))
            0: len = 16'($urandom_range(0, MIN_REPLY_LEN - 1));
            1: typ = typ ^ flip;
            2: code = code ^ flip;
            default: proto = proto ^ flip;
         endcase
         offer_item(OP_REPLY, clock_ms, len, typ, code, proto, port);
      end else if (pick < 88) begin
         offer_item(OP_EXPIRE, clock_ms, '0, '0, '0, '0, port);
      end else if (pick < 95) begin
         offer_item(OP_STATS, clock_ms, '0, '0, '0, '0, port);
      end else begin
         offer_item(2'($urandom_range(0, 3)), random_ms(), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), port);
      end
   endtask

   initial begin
      int n;
      n = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part, at reset register values
      offer_item(OP_REPLY, 48'd10, 16'd100, ICMP_TIME_EXCEEDED, ICMP_TTL_IN_TRANSIT,
                 PROTO_UDP, 16'd4041);
      offer_item(OP_STATS, '0, '0, '0, '0, '0, '0);
      offer_item(OP_EXPIRE, NOW_MAX, '0, '0, '0, '0, '0);
      offer_item(OP_SEND, 48'd1000, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      offer_item(OP_SEND, NOW_MAX, '0, '0, '0, '0, '0);
      offer_item(OP_REPLY, 48'd2000, MIN_REPLY_LEN - 16'd1, ICMP_TIME_EXCEEDED,
                 ICMP_TTL_IN_TRANSIT, PROTO_UDP, 16'd4041);
      offer_item(OP_REPLY, 48'd2000, MIN_REPLY_LEN, 8'hFF, ICMP_TTL_IN_TRANSIT,
                 PROTO_UDP, 16'd4041);
      offer_item(OP_REPLY, 48'd2000, MIN_REPLY_LEN, ICMP_TIME_EXCEEDED, 8'hFF,
                 PROTO_UDP, 16'd4041);
      offer_item(OP_REPLY, 48'd2000, MIN_REPLY_LEN, ICMP_TIME_EXCEEDED,
                 ICMP_TTL_IN_TRANSIT, 8'hFF, 16'd4041);
      offer_item(OP_REPLY, 48'd2000, MIN_REPLY_LEN, ICMP_TIME_EXCEEDED,
                 ICMP_TTL_IN_TRANSIT, PROTO_UDP, 16'd4041);
      offer_item(OP_REPLY, 48'd2000, MIN_REPLY_LEN, ICMP_TIME_EXCEEDED,
                 ICMP_TTL_IN_TRANSIT, PROTO_UDP, 16'd4041);
      offer_item(OP_REPLY, 48'd2000, 16'hFFFF, ICMP_TIME_EXCEEDED,
                 ICMP_TTL_IN_TRANSIT, PROTO_UDP, 16'hFFFF);
      offer_item(OP_SEND, 48'd1000, '0, '0, '0, '0, '0);
      // deadline exactly equal to now stays, one past it goes
      offer_item(OP_EXPIRE, 48'd6000, '0, '0, '0, '0, '0);
      offer_item(OP_EXPIRE, 48'd6001, '0, '0, '0, '0, '0);
      offer_item(OP_EXPIRE, NOW_MAX, '0, '0, '0, '0, '0);
      offer_item(OP_STATS, '0, '0, '0, '0, '0, '0);
      offer_item(OP_REPLY, 48'd7000, 16'd1500, ICMP_TIME_EXCEEDED,
                 ICMP_TTL_IN_TRANSIT, PROTO_UDP, 16'd4042);
      offer_item(OP_REPLY, 48'd7000, '0, 8'hFF, 8'hFF, 8'hFF, 16'd4042);
      offer_item(OP_STATS, NOW_MAX, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      settle();

      // nothing may be sent with a limit of zero
      apply_settings(16'd0, 16'hFFFF, 16'd0);
      offer_item(OP_SEND, clock_ms, '0, '0, '0, '0, '0);
      offer_item(OP_SEND, clock_ms, '0, '0, '0, '0, '0);
      settle();

      // limit above the table size: the table itself refuses the last sends
      apply_settings(16'hFFFF, 16'd0, 16'hFFFF);
      repeat (TABLE_DEPTH + 2) offer_item(OP_SEND, clock_ms, '0, '0, '0, '0, '0);
      offer_item(OP_EXPIRE, NOW_MAX, '0, '0, '0, '0, '0);
      offer_item(OP_STATS, '0, '0, '0, '0, '0, '0);
      settle();
      granted_seqs.delete();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: apply_settings(16'd50, 16'd1024, 16'd5000);
            1: apply_settings(16'd64, 16'hFFFF, 16'd0);
            2: apply_settings(16'($urandom_range(1, 64)), 16'($urandom_range(0, 65535)),
                              16'hFFFF);
            default: apply_settings(16'd1, 16'd0, 16'($urandom_range(0, 65535)));
         endcase
         repeat (RANDOM_ITEMS / 4) begin
            req_no_idle = (n >= 200 && n < 320);
            if (n == 60) pressure_req <= pressure_req + 1;
            random_item();
            n++;
         end
         settle();
      end

      $display("summary: %0d items over %0d register settings, %0d probes granted, %0d matched",
               items_sent, settings_used, grants_seen, matches_seen);
      $display("covered empty-table replies, header rejects, expiry bounds and a full table");
      if (fail_count == 0 && pending_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: outstanding_probe_tracker_core.f
rtl/opt_pkg.sv
rtl/outstanding_probe_tracker_core.sv
dv/probe_tracker_checker.sv
dv/testbench.sv
